// ===== rtl/espwm_pkg.sv =====
// Shared types, constants and helpers for the eight-step PWM sequencer.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package espwm_pkg;

	// Sequencer geometry
	localparam int unsigned STEPS = 8;
	localparam int unsigned IDX_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	// Field widths fixed by the interface
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned REG_W    = 16;
	localparam int unsigned STEP_W   = 3;
	localparam int unsigned PROD_W   = SAMPLE_W + REG_W;

	// Configuration register map
	localparam int unsigned CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_STEP = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PWM_PERIOD     = 1'd1;

	// Register reset values
	localparam logic [REG_W-1:0] RST_TICKS_PER_STEP = 16'd1000;
	localparam logic [REG_W-1:0] RST_PWM_PERIOD     = 16'd11999;
	localparam logic [REG_W-1:0] RST_COMPARE        = REG_W'(RST_PWM_PERIOD / 2);

	// Full-scale converter code used as divisor of the duty scaling
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

	// Step table reset pattern, repeated every eight entries
	localparam logic [SAMPLE_W-1:0] RESET_PATTERN [8] = '{
		12'd4000, 12'd2000, 12'd0, 12'd2000, 12'd4000, 12'd2000, 12'd0, 12'd2000
	};

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_PAUSE = 2'd1,
		CMD_STORE = 2'd2
	} cmd_t;

	// Fields that travel alongside the duty calculation
	typedef struct packed {
		logic              pwm_enable;
		logic [STEP_W-1:0] play_step;
		logic [STEP_W-1:0] edit_step;
		logic              advanced;
	} side_t;

	// Stage load enables handed to the scaling pipeline
	typedef struct packed {
		logic s2;
		logic s3;
	} pipe_en_t;

	function automatic logic [SAMPLE_W-1:0] reset_entry(input int unsigned idx);
		logic [2:0] sel;
		sel = idx[2:0];
		return RESET_PATTERN[sel];
	endfunction

endpackage

// ===== rtl/espwm_ctrl.sv =====
// Sequencer state: tick counter, play/edit indices, pause flag and step table.
// Produces the first pipeline stage. Depends on espwm_pkg.
module espwm_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [espwm_pkg::CMD_W-1:0]         cmd,
	input  logic [espwm_pkg::SAMPLE_W-1:0]      sample,
	input  logic [espwm_pkg::REG_W-1:0]         ticks_per_step,
	output logic [espwm_pkg::SAMPLE_W-1:0]      entry_s1,
	output espwm_pkg::side_t                    side_s1
);

	logic [espwm_pkg::REG_W-1:0]    tick_q, tick_d;
	logic [espwm_pkg::REG_W:0]      tick_inc;
	logic                           wrap;
	logic [espwm_pkg::IDX_W-1:0]    play_q, play_d, play_nxt;
	logic [espwm_pkg::IDX_W-1:0]    edit_q, edit_d, edit_nxt;
	logic                           paused_q, paused_d;
	logic                           adv;
	logic                           store_we;
	logic [espwm_pkg::SAMPLE_W-1:0] step_q [espwm_pkg::STEPS];

	assign tick_inc = {1'b0, tick_q} + 17'd1;
	// a step length of zero behaves like one
	assign wrap     = tick_inc >= {1'b0, ticks_per_step};
	assign play_nxt = (play_q == espwm_pkg::IDX_W'(espwm_pkg::STEPS - 1)) ? '0 : play_q + 1'b1;
	assign edit_nxt = (edit_q == espwm_pkg::IDX_W'(espwm_pkg::STEPS - 1)) ? '0 : edit_q + 1'b1;

	always_comb begin
		tick_d   = tick_q;
		play_d   = play_q;
		edit_d   = edit_q;
		paused_d = paused_q;
		adv      = 1'b0;
		store_we = 1'b0;
		case (espwm_pkg::cmd_t'(cmd))
			espwm_pkg::CMD_TICK: begin
				if (!paused_q) begin
					if (wrap) begin
						tick_d = '0;
						play_d = play_nxt;
						adv    = 1'b1;
					end else begin
						tick_d = tick_inc[espwm_pkg::REG_W-1:0];
					end
				end
			end
			espwm_pkg::CMD_PAUSE: begin
				paused_d = !paused_q;
			end
			espwm_pkg::CMD_STORE: begin
				store_we = 1'b1;
				edit_d   = edit_nxt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			play_q   <= '0;
			edit_q   <= '0;
			paused_q <= 1'b0;
			for (int i = 0; i < espwm_pkg::STEPS; i++) begin
				step_q[i] <= espwm_pkg::reset_entry(i);
			end
		end else if (accept) begin
			tick_q   <= tick_d;
			play_q   <= play_d;
			edit_q   <= edit_d;
			paused_q <= paused_d;
			if (store_we) begin
				step_q[edit_q] <= sample;
			end
		end
	end

	// stage 1 payload; entry only matters when the beat advanced
	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1            <= step_q[play_nxt];
			side_s1.pwm_enable  <= !paused_d;
			side_s1.play_step   <= espwm_pkg::STEP_W'(play_d);
			side_s1.edit_step   <= espwm_pkg::STEP_W'(edit_d);
			side_s1.advanced    <= adv;
		end
	end

endmodule

// ===== rtl/espwm_scale.sv =====
// Duty scaling pipeline: entry * period, then divide by 4095 via shift-add estimate
// and a one-step remainder correction. Depends on espwm_pkg.
module espwm_scale (
	input  logic                           clk,
	input  espwm_pkg::pipe_en_t            en,
	input  logic [espwm_pkg::SAMPLE_W-1:0] entry_s1,
	input  logic [espwm_pkg::REG_W-1:0]    pwm_period,
	output logic [espwm_pkg::REG_W-1:0]    quot
);

	logic [espwm_pkg::PROD_W-1:0] prod_s2;
	logic [espwm_pkg::PROD_W:0]   est_sum;
	logic [espwm_pkg::REG_W-1:0]  qest_s3;
	logic [13:0]                  xlo_s3;
	logic [13:0]                  rem;

	// x/4095 = (x + x/4095)/4096; x>>12 stands in for x/4095, which leaves the estimate low by at most one
	assign est_sum = {1'b0, prod_s2} + espwm_pkg::PROD_W'(prod_s2 >> 12) + 1'b0;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= espwm_pkg::PROD_W'(entry_s1) * espwm_pkg::PROD_W'(pwm_period);
		end
		if (en.s3) begin
			qest_s3 <= espwm_pkg::REG_W'(est_sum >> 12);
			xlo_s3  <= prod_s2[13:0];
		end
	end

	// remainder lies in [0, 2*4095), so 14 bits modulo arithmetic is exact
	assign rem  = xlo_s3 - {qest_s3[1:0], 12'd0} + qest_s3[13:0];
	assign quot = (rem >= 14'(espwm_pkg::FULL_SCALE)) ? qest_s3 + 1'b1 : qest_s3;

endmodule

// ===== rtl/eight_step_pwm_sequencer_unit.sv =====
// Eight-step PWM sequencer, top level.
// Holds the configuration registers, the beat pipeline and the output register.
// Depends on espwm_pkg, espwm_ctrl and espwm_scale.
//
// Takes one command beat per clock unless stalled (tick, pause toggle or sample
// store) and returns exactly one result beat per command, in order. Sequencer
// state (tick counter, play and edit indices, pause flag, step table) updates in
// the cycle a beat is accepted, so back-to-back beats see each other's effects
// at once. The compare value for an advancing tick, entry * pwm_period / 4095,
// comes out of a short pipeline: stage 1 reads the entry, stage 2 forms the
// 28-bit product, stage 3 makes a shift-add quotient estimate, and the output
// register applies a one-step remainder fix and holds the compare value between
// advances. Sustained rate is one beat per cycle without stalls. Each stage
// holds its beat until the next one frees, so gaps close up and the input keeps
// taking beats into free stages while a finished result waits on the output.
// Configuration writes (index 0 ticks_per_step, index 1 pwm_period) are expected
// only when the block is drained; the compare value keeps its value across a
// period change until the next advance. Reset loads the step table with its
// default pattern and the compare value with half the reset period.
module eight_step_pwm_sequencer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [espwm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [espwm_pkg::REG_W-1:0]          cfg_wdata,
	// command channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [espwm_pkg::CMD_W-1:0]          cmd,
	input  logic [espwm_pkg::SAMPLE_W-1:0]       sample,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [espwm_pkg::REG_W-1:0]          duty_compare,
	output logic                                 pwm_enable,
	output logic [espwm_pkg::STEP_W-1:0]         play_step,
	output logic [espwm_pkg::STEP_W-1:0]         edit_step,
	output logic                                 step_advanced
);

	// configuration registers
	logic [espwm_pkg::REG_W-1:0] ticks_per_step_q;
	logic [espwm_pkg::REG_W-1:0] pwm_period_q;

	// pipeline occupancy
	logic v1_q, v2_q, v3_q, vo_q;
	logic en1, en2, en3, eno;
	logic accept;
	espwm_pkg::pipe_en_t pen;

	// beat payload per stage
	logic [espwm_pkg::SAMPLE_W-1:0] entry_s1;
	espwm_pkg::side_t               side_s1, side_s2, side_s3, side_q;
	logic [espwm_pkg::REG_W-1:0]    quot;
	logic [espwm_pkg::REG_W-1:0]    compare_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_step_q <= espwm_pkg::RST_TICKS_PER_STEP;
			pwm_period_q     <= espwm_pkg::RST_PWM_PERIOD;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				espwm_pkg::REG_TICKS_PER_STEP: ticks_per_step_q <= cfg_wdata;
				espwm_pkg::REG_PWM_PERIOD:     pwm_period_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// a stage loads when empty or when its beat moves on
	assign eno      = !vo_q || out_ready;
	assign en3      = !v3_q || eno;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign in_ready = en1;
	assign accept   = in_valid && en1;
	assign pen      = '{s2: en2, s3: en3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1) v1_q <= in_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (eno) vo_q <= v3_q;
		end
	end

	espwm_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.cmd            (cmd),
		.sample         (sample),
		.ticks_per_step (ticks_per_step_q),
		.entry_s1       (entry_s1),
		.side_s1        (side_s1)
	);

	// the user must keep pwm_period stable while beats are in flight; the block does not enforce it
	espwm_scale u_scale (
		.clk        (clk),
		.en         (pen),
		.entry_s1   (entry_s1),
		.pwm_period (pwm_period_q),
		.quot       (quot)
	);

	always_ff @(posedge clk) begin
		if (en2) side_s2 <= side_s1;
		if (en3) side_s3 <= side_s2;
		if (eno) side_q  <= side_s3;
	end

	// compare value is state: only an advancing beat replaces it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_q <= espwm_pkg::RST_COMPARE;
		end else if (eno && v3_q && side_s3.advanced) begin
			compare_q <= quot;
		end
	end

	assign out_valid     = vo_q;
	assign duty_compare  = compare_q;
	assign pwm_enable    = side_q.pwm_enable;
	assign play_step     = side_q.play_step;
	assign edit_step     = side_q.edit_step;
	assign step_advanced = side_q.advanced;

`ifndef SYNTHESIS
	// an advance only happens on a running tick
	a_adv_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_advanced |-> pwm_enable)
		else $error("step advanced while paused");

	// an empty output stage must never block the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// compare value only moves on an advancing beat
	a_compare_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !step_advanced && $past(out_valid) |-> $stable(duty_compare))
		else $error("compare value changed without an advance");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking regression bench for eight_step_pwm_sequencer_unit.
// Depends on espwm_pkg and the sequencer RTL; stands alone otherwise.
// Drives commands with random bursts and checks each result beat against a local model.
module tb;

	// cmd value that the block has no operation for
	localparam logic [espwm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	// divisor of the duty scaling, full-scale converter code
	localparam int unsigned FULL_CODE = 4095;
	// cycles left after the last result before the block counts as idle
	localparam int unsigned SETTLE = 8;
	// hard stop, far beyond the slowest correct run
	localparam int unsigned LIMIT_CYCLES = 300000;

	// step table after reset
	localparam logic [espwm_pkg::SAMPLE_W-1:0] BOOT_TABLE [8] = '{
		12'd4000, 12'd2000, 12'd0, 12'd2000, 12'd4000, 12'd2000, 12'd0, 12'd2000
	};

	typedef struct packed {
		logic [espwm_pkg::REG_W-1:0]  duty;
		logic                         en;
		logic [espwm_pkg::STEP_W-1:0] play;
		logic [espwm_pkg::STEP_W-1:0] edit;
		logic                         adv;
	} result_t;

	typedef enum logic [1:0] {
		PEND_BEAT,
		PEND_CFG,
		PEND_DRAIN
	} pend_kind_t;

	typedef struct {
		pend_kind_t                       kind;
		logic [espwm_pkg::CMD_W-1:0]      c;
		logic [espwm_pkg::SAMPLE_W-1:0]   s;
		logic [espwm_pkg::CFG_ADDR_W-1:0] a;
		logic [espwm_pkg::REG_W-1:0]      d;
	} pend_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_wr_en = 1'b0;
	logic [espwm_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [espwm_pkg::REG_W-1:0]      cfg_wdata = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [espwm_pkg::CMD_W-1:0]      cmd = espwm_pkg::CMD_TICK;
	logic [espwm_pkg::SAMPLE_W-1:0]   sample = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [espwm_pkg::REG_W-1:0]      duty_compare;
	logic                             pwm_enable;
	logic [espwm_pkg::STEP_W-1:0]     play_step;
	logic [espwm_pkg::STEP_W-1:0]     edit_step;
	logic                             step_advanced;

	eight_step_pwm_sequencer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.duty_compare  (duty_compare),
		.pwm_enable    (pwm_enable),
		.play_step     (play_step),
		.edit_step     (edit_step),
		.step_advanced (step_advanced)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Sequencer model: own copy of table, counters and registers.
	// Only the driver process touches these.
	// ---------------------------------------------------------------
	logic [espwm_pkg::SAMPLE_W-1:0] step_tab [8];
	logic [espwm_pkg::REG_W-1:0]    seq_ticks;
	logic [espwm_pkg::STEP_W-1:0]   seq_play;
	logic [espwm_pkg::STEP_W-1:0]   seq_edit;
	logic                           seq_paused;
	logic [espwm_pkg::REG_W-1:0]    seq_cmp;
	logic [espwm_pkg::REG_W-1:0]    cfg_tps;
	logic [espwm_pkg::REG_W-1:0]    cfg_period;

	// Bookkeeping shared between driver and monitor. n_sent and n_got move by
	// nonblocking assignment so each side sees the other's previous value.
	pend_t   pend_q [$];
	result_t expect_q [$];
	int      n_sent = 0;
	int      n_got = 0;
	int      errors = 0;
	int      adv_seen = 0;
	int      cfg_writes = 0;
	int      drain_holds = 0;

	task automatic report_mismatch(input string what, input longint got_v,
			input longint want_v);
		$display("MISMATCH %s at result %0d: got %0d, want %0d", what, n_got, got_v,
			want_v);
		errors++;
	endtask

	function automatic void model_reset();
		for (int i = 0; i < 8; i++)
			step_tab[i] = BOOT_TABLE[i];
		seq_ticks  = '0;
		seq_play   = '0;
		seq_edit   = '0;
		seq_paused = 1'b0;
		cfg_tps    = 16'd1000;
		cfg_period = 16'd11999;
		seq_cmp    = cfg_period / 16'd2;
	endfunction

	// Applies one accepted command beat to the model and returns the result beat.
	function automatic result_t predict_beat(input logic [espwm_pkg::CMD_W-1:0] c,
			input logic [espwm_pkg::SAMPLE_W-1:0] s);
		result_t     r;
		logic [16:0] nxt;
		logic [31:0] prod;
		r.adv = 1'b0;
		if (c == espwm_pkg::CMD_TICK) begin
			if (!seq_paused) begin
				nxt = {1'b0, seq_ticks} + 17'd1;
				// a zero step length behaves as one
				if (nxt >= {1'b0, cfg_tps}) begin
					seq_ticks = '0;
					seq_play  = seq_play + 3'd1;
					prod      = 32'(step_tab[seq_play]) * 32'(cfg_period);
					seq_cmp   = 16'(prod / FULL_CODE);
					r.adv     = 1'b1;
				end else begin
					seq_ticks = nxt[15:0];
				end
			end
		end else if (c == espwm_pkg::CMD_PAUSE) begin
			seq_paused = !seq_paused;
		end else if (c == espwm_pkg::CMD_STORE) begin
			step_tab[seq_edit] = s;
			seq_edit = seq_edit + 3'd1;
		end
		// unused command: state stays, result mirrors it
		r.duty = seq_cmp;
		r.en   = !seq_paused;
		r.play = seq_play;
		r.edit = seq_edit;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Driver: pops the pending list, works in bursts with gaps, holds
	// register writes and drain markers until the block is idle.
	// ---------------------------------------------------------------
	int gap_left = 0;
	int burst_left = 1;
	int quiet_cnt = 0;

	always @(posedge clk) begin : drive_proc
		logic                             nv;
		logic                             nwr;
		logic [espwm_pkg::CMD_W-1:0]      ncmd;
		logic [espwm_pkg::SAMPLE_W-1:0]   nsamp;
		logic [espwm_pkg::CFG_ADDR_W-1:0] naddr;
		logic [espwm_pkg::REG_W-1:0]      ndata;
		int                               cur_sent;
		pend_t                            head;
		if (!arst_n) begin
			model_reset();
		end else begin
			nv       = in_valid;
			nwr      = 1'b0;
			ncmd     = cmd;
			nsamp    = sample;
			naddr    = cfg_addr;
			ndata    = cfg_wdata;
			cur_sent = n_sent;

			// the block takes the write at this edge, so does the model
			if (cfg_wr_en) begin
				if (cfg_addr == espwm_pkg::REG_TICKS_PER_STEP)
					cfg_tps = cfg_wdata;
				else if (cfg_addr == espwm_pkg::REG_PWM_PERIOD)
					cfg_period = cfg_wdata;
				cfg_writes++;
			end

			if (in_valid && in_ready) begin
				expect_q.push_back(predict_beat(cmd, sample));
				cur_sent = cur_sent + 1;
				nv = 1'b0;
			end

			// idle means nothing on the bus and every result back
			if (!nv && !cfg_wr_en && n_got == cur_sent)
				quiet_cnt++;
			else
				quiet_cnt = 0;

			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_q.size() > 0) begin
					head = pend_q[0];
					case (head.kind)
						PEND_BEAT: begin
							nv    = 1'b1;
							ncmd  = head.c;
							nsamp = head.s;
							void'(pend_q.pop_front());
							burst_left--;
							if (burst_left <= 0) begin
								burst_left = $urandom_range(1, 40);
								gap_left = ($urandom_range(0, 3) == 0) ? 0 :
									$urandom_range(1, 6);
							end
						end
						PEND_CFG: begin
							if (quiet_cnt >= SETTLE) begin
								nwr   = 1'b1;
								naddr = head.a;
								ndata = head.d;
								void'(pend_q.pop_front());
							end
						end
						default: begin
							if (quiet_cnt >= SETTLE) begin
								drain_holds++;
								void'(pend_q.pop_front());
							end
						end
					endcase
				end
			end

			n_sent    <= cur_sent;
			in_valid  <= nv;
			cmd       <= ncmd;
			sample    <= nsamp;
			cfg_wr_en <= nwr;
			cfg_addr  <= naddr;
			cfg_wdata <= ndata;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: stalls on a rotating 16-bit ready mask, reshuffled whenever the
	// low six bits of its counter wrap, and checks each accepted result beat in order.
	// ---------------------------------------------------------------
	logic [15:0] rdy_pat = '1;
	logic [31:0] rdy_cnt = '0;

	always @(posedge clk) begin : mon_proc
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (n_got >= n_sent) begin
					report_mismatch("result beat with none outstanding", duty_compare, 0);
				end else begin
					want = expect_q[n_got];
					if (duty_compare !== want.duty)
						report_mismatch("duty_compare", duty_compare, want.duty);
					if (pwm_enable !== want.en)
						report_mismatch("pwm_enable", pwm_enable, want.en);
					if (play_step !== want.play)
						report_mismatch("play_step", play_step, want.play);
					if (edit_step !== want.edit)
						report_mismatch("edit_step", edit_step, want.edit);
					if (step_advanced !== want.adv)
						report_mismatch("step_advanced", step_advanced, want.adv);
					if (want.adv)
						adv_seen++;
					n_got <= n_got + 1;
				end
			end

			rdy_cnt = rdy_cnt + 1;
			if (rdy_cnt[5:0] == 6'd0) begin
				case ($urandom_range(0, 2))
					0: rdy_pat = '1;
					1: rdy_pat = 16'($urandom);
					default: rdy_pat = 16'($urandom & $urandom);
				endcase
				if (rdy_pat == 16'd0)
					rdy_pat = 16'h0001;
			end
			out_ready <= rdy_pat[rdy_cnt[3:0]];
		end
	end

	// ---------------------------------------------------------------
	// Stimulus list helpers
	// ---------------------------------------------------------------
	task automatic push_beat(input logic [espwm_pkg::CMD_W-1:0] c,
			input logic [espwm_pkg::SAMPLE_W-1:0] s);
		pend_t p;
		p.kind = PEND_BEAT;
		p.c = c;
		p.s = s;
		p.a = '0;
		p.d = '0;
		pend_q.push_back(p);
	endtask

	task automatic push_cfg(input logic [espwm_pkg::CFG_ADDR_W-1:0] a,
			input logic [espwm_pkg::REG_W-1:0] d);
		pend_t p;
		p.kind = PEND_CFG;
		p.c = espwm_pkg::CMD_TICK;
		p.s = '0;
		p.a = a;
		p.d = d;
		pend_q.push_back(p);
	endtask

	task automatic push_drain();
		pend_t p;
		p.kind = PEND_DRAIN;
		p.c = espwm_pkg::CMD_TICK;
		p.s = '0;
		p.a = '0;
		p.d = '0;
		pend_q.push_back(p);
	endtask

	// hard timeout
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("TIMEOUT after %0d cycles, %0d of %0d results back", cycles, n_got, n_sent);
		$display("eight_step_pwm_sequencer_unit regression: fail");
		$finish;
	end

	initial begin : stim
		int                             n_beats;
		int                             roll;
		logic [espwm_pkg::CMD_W-1:0]    c;
		logic [espwm_pkg::SAMPLE_W-1:0] s;
		logic [espwm_pkg::REG_W-1:0]    tps;
		logic [espwm_pkg::REG_W-1:0]    per;

		// -- directed: reset registers, one tick short of nothing, stores, pause
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_beat(espwm_pkg::CMD_STORE, 12'hFFF);
		push_beat(espwm_pkg::CMD_STORE, 12'h000);
		push_beat(espwm_pkg::CMD_PAUSE, 12'h000);
		push_beat(espwm_pkg::CMD_TICK, 12'hFFF);     // paused tick: no change
		push_beat(CMD_UNUSED, 12'hFFF);              // unused command: no change
		push_beat(espwm_pkg::CMD_PAUSE, 12'h000);
		push_beat(CMD_UNUSED, 12'h000);

		// -- every tick advances; full-scale period gives the top compare value
		push_cfg(espwm_pkg::REG_TICKS_PER_STEP, 16'd1);
		push_cfg(espwm_pkg::REG_PWM_PERIOD, 16'hFFFF);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_beat(espwm_pkg::CMD_STORE, 12'hFFF);
		push_beat(espwm_pkg::CMD_STORE, 12'h001);
		push_beat(espwm_pkg::CMD_STORE, 12'h800);
		push_beat(espwm_pkg::CMD_STORE, 12'hFFE);
		push_beat(espwm_pkg::CMD_STORE, 12'hAAA);
		push_beat(espwm_pkg::CMD_STORE, 12'h555);    // edit index wraps to zero
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);

		// -- zero step length and zero period
		push_cfg(espwm_pkg::REG_TICKS_PER_STEP, 16'd0);
		push_cfg(espwm_pkg::REG_PWM_PERIOD, 16'd0);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);

		// -- step length lowered below the running count; period change
		//    leaves the compare value alone until the next advance
		push_cfg(espwm_pkg::REG_TICKS_PER_STEP, 16'd5);
		push_cfg(espwm_pkg::REG_PWM_PERIOD, 16'd4095);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_drain();
		push_cfg(espwm_pkg::REG_TICKS_PER_STEP, 16'd2);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_cfg(espwm_pkg::REG_PWM_PERIOD, 16'd1);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);
		push_beat(espwm_pkg::CMD_TICK, 12'd0);

		// -- random phases, each with its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: tps = 16'd1;
				1: tps = 16'd0;
				2: tps = 16'hFFFF;
				3: tps = 16'($urandom_range(2, 20));
				default: tps = 16'($urandom_range(1, 6));
			endcase
			case (ph)
				0: per = 16'hFFFF;
				1: per = 16'd1;
				2: per = 16'd0;
				3: per = 16'd11999;
				default: per = 16'($urandom);
			endcase
			push_cfg(espwm_pkg::REG_TICKS_PER_STEP, tps);
			push_cfg(espwm_pkg::REG_PWM_PERIOD, per);
			// a step length this long never advances; keep that phase short
			n_beats = (tps > 16'd100) ? 40 : 125;
			for (int i = 0; i < n_beats; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 62)
					c = espwm_pkg::CMD_TICK;
				else if (roll < 88)
					c = espwm_pkg::CMD_STORE;
				else if (roll < 96)
					c = espwm_pkg::CMD_PAUSE;
				else
					c = CMD_UNUSED;
				case ($urandom_range(0, 7))
					0: s = '0;
					1: s = '1;
					default: s = 12'($urandom);
				endcase
				push_beat(c, s);
				if ($urandom_range(0, 79) == 0)
					push_drain();
			end
		end

		// reset held from the start, released once
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// sample between edges so the driver's updates have all landed
		while (!(pend_q.size() == 0 && !in_valid && !cfg_wr_en && n_got == n_sent))
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);

		if (n_got != n_sent)
			report_mismatch("results never returned", n_got, n_sent);

		$display("Covered %0d command beats, %0d of them advancing ticks,", n_sent, adv_seen);
		$display("across %0d register writes and %0d full drains.", cfg_writes, drain_holds);
		if (errors == 0) begin
			$display("eight_step_pwm_sequencer_unit regression: pass");
		end else begin
			$display("eight_step_pwm_sequencer_unit regression: fail");
		end
		$finish;
	end

endmodule
